// File: hdl/psseq_pkg.sv
// shared types, constants and helper functions of the pattern step sequencer
package psseq_pkg;

	// fixed field widths
	localparam int unsigned PERIOD_W  = 10;
	localparam int unsigned INCR_W    = 8;
	localparam int unsigned MODES_W   = 12;
	localparam int unsigned PATTERN_W = 48;
	localparam int unsigned ACC_W     = 16;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned CMD_W     = 8;
	localparam int unsigned CODE_W    = 4;
	localparam int unsigned VIDX_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned LANE_W    = 16;

	// default sizes handed to the top level
	localparam int unsigned VOICE_COUNT_DEF = 6;
	localparam int unsigned STEP_COUNT_DEF  = 16;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_INCREMENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERNS_LO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERNS_HI    = 3'd4;

	// register reset values
	localparam logic [PERIOD_W-1:0]  RST_STEP_PERIOD    = 10'd32;
	localparam logic [INCR_W-1:0]    RST_TICK_INCREMENT = 8'd2;
	localparam logic [MODES_W-1:0]   RST_CHANNEL_MODES  = 12'd1365;

	// voice modes
	localparam logic [1:0] MODE_SILENT  = 2'd0;
	localparam logic [1:0] MODE_PATTERN = 2'd1;

	// high nibble of a key command
	localparam logic [CODE_W-1:0] SLOT_RELEASE = 4'h0;
	localparam logic [CODE_W-1:0] SLOT_STRIKE  = 4'hF;

	// voice settings used by the back part
	typedef struct packed {
		logic [MODES_W-1:0]   modes;
		logic [PATTERN_W-1:0] patterns_lo;
		logic [PATTERN_W-1:0] patterns_hi;
	} voice_cfg_t;

	// back part status
	typedef struct packed {
		logic busy;
		logic strike_pending;
	} back_status_t;

	// key register channel code of a voice
	function automatic logic [CODE_W-1:0] voice_code(input logic [VIDX_W-1:0] voice);
		logic [CODE_W-1:0] code;
		unique case (voice)
			3'd0:    code = 4'd0;
			3'd1:    code = 4'd1;
			3'd2:    code = 4'd2;
			3'd3:    code = 4'd4;
			3'd4:    code = 4'd5;
			3'd5:    code = 4'd6;
			default: code = 4'd0;
		endcase
		return code;
	endfunction

	// step mask bit of a voice at a position
	function automatic logic pattern_bit(input voice_cfg_t cfg,
		input logic [VIDX_W-1:0] voice, input logic [POS_W-1:0] pos);
		logic [PATTERN_W-1:0] word;
		logic [LANE_W-1:0]    lane;
		word = (voice < 3'd3) ? cfg.patterns_lo : cfg.patterns_hi;
		unique case (voice)
			3'd0, 3'd3: lane = word[0 +: LANE_W];
			3'd1, 3'd4: lane = word[LANE_W +: LANE_W];
			3'd2, 3'd5: lane = word[2*LANE_W +: LANE_W];
			default:    lane = '0;
		endcase
		return lane[pos];
	endfunction

endpackage

// File: hdl/psseq_front.sv
// front part: tick accumulator, step detection and position counter
module psseq_front import psseq_pkg::*; #(
	parameter int unsigned STEP_COUNT = STEP_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                advance,
	input  logic [PERIOD_W-1:0] step_period,
	input  logic [INCR_W-1:0]   tick_increment,
	output logic                enq,
	output logic [POS_W-1:0]    enq_pos
);

	logic [ACC_W-1:0] acc_q;
	logic [POS_W-1:0] pos_q;
	logic [ACC_W:0]   sum;
	logic [ACC_W-1:0] sat;
	logic             hit;
	logic [POS_W-1:0] pos_next;

	// saturating add and threshold compare
	always_comb begin
		sum      = {1'b0, acc_q} + (ACC_W + 1)'(tick_increment);
		sat      = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
		hit      = sat >= ACC_W'(step_period);
		pos_next = (pos_q == POS_W'(STEP_COUNT - 1)) ? '0 : pos_q + 1'b1;
		enq      = take && advance && hit;
		enq_pos  = pos_next;
	end

	// accumulator and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (take && advance) begin
			if (hit) begin
				acc_q <= sat - ACC_W'(step_period);
				pos_q <= pos_next;
			end else begin
				acc_q <= sat;
			end
		end
	end

endmodule

// File: hdl/psseq_queue.sv
// short queue of step positions between front and back
module psseq_queue import psseq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  logic [POS_W-1:0]  wr_data,
	input  logic              rd,
	output logic [POS_W-1:0]  rd_data,
	output logic              full,
	output logic              avail,
	output logic [QCNT_W-1:0] count
);

	logic [POS_W-1:0]  slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign avail   = count_q != '0;
	assign count   = count_q;
	assign rd_data = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/psseq_back.sv
// back part: voice walk, key state and result register
module psseq_back import psseq_pkg::*; #(
	parameter int unsigned VOICE_COUNT = VOICE_COUNT_DEF,
	localparam int unsigned VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  voice_cfg_t         cfg,
	input  logic               job_avail,
	input  logic [POS_W-1:0]   job_pos,
	output logic               job_take,
	input  logic               pop,
	output logic               empty,
	output logic [CMD_W-1:0]   key_command,
	output logic               last_of_run,
	output back_status_t       status,
	output logic [VOICE_W-1:0] voice
);

	logic                   busy_q;
	logic                   phase_q;
	logic [VOICE_W-1:0]     voice_q;
	logic [POS_W-1:0]       pos_q;
	logic [VOICE_COUNT-1:0] held_q;
	logic                   out_valid_q;
	logic [CMD_W-1:0]       cmd_q;
	logic                   last_q;

	logic [VOICE_COUNT-1:0] emits;
	logic                   later;
	logic [1:0]             mode;
	logic                   held;
	logic                   pat;
	logic [CODE_W-1:0]      code;
	logic                   emit;
	logic                   strike;
	logic                   last;
	logic                   next_phase;
	logic                   held_next;
	logic                   space;
	logic                   go;

	// which voices of this step give a command, and whether one follows the current voice
	always_comb begin
		logic [1:0] m;
		later = 1'b0;
		for (int i = 0; i < VOICE_COUNT; i++) begin
			m = cfg.modes[2*i +: 2];
			if (m == MODE_SILENT) begin
				emits[i] = held_q[i];
			end else if (m == MODE_PATTERN) begin
				emits[i] = 1'b1;
			end else begin
				emits[i] = !held_q[i];
			end
			if (emits[i] && (VOICE_W'(i) > voice_q)) begin
				later = 1'b1;
			end
		end
	end

	// action of the current voice
	always_comb begin
		mode       = cfg.modes[{voice_q, 1'b0} +: 2];
		held       = held_q[voice_q];
		pat        = pattern_bit(cfg, VIDX_W'(voice_q), pos_q);
		code       = voice_code(VIDX_W'(voice_q));
		emit       = 1'b0;
		strike     = 1'b0;
		last       = !later;
		next_phase = 1'b0;
		held_next  = held;
		if (phase_q) begin
			emit      = 1'b1;
			strike    = 1'b1;
			held_next = 1'b1;
		end else begin
			unique case (mode)
				MODE_SILENT: begin
					emit      = held;
					held_next = 1'b0;
				end
				MODE_PATTERN: begin
					emit       = 1'b1;
					held_next  = 1'b0;
					next_phase = pat;
					last       = !later && !pat;
				end
				default: begin
					emit      = !held;
					strike    = 1'b1;
					held_next = 1'b1;
				end
			endcase
		end
		space    = !out_valid_q || pop;
		go       = busy_q && (!emit || space);
		job_take = !busy_q && job_avail;
	end

	// walk control and key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			voice_q <= '0;
			held_q  <= '0;
		end else if (job_take) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			voice_q <= '0;
		end else if (go) begin
			held_q[voice_q] <= held_next;
			phase_q         <= next_phase;
			if (!next_phase) begin
				if (voice_q == VOICE_W'(VOICE_COUNT - 1)) begin
					busy_q  <= 1'b0;
					voice_q <= '0;
				end else begin
					voice_q <= voice_q + 1'b1;
				end
			end
		end
	end

	// step position of the job being walked
	always_ff @(posedge clk) begin
		if (job_take) begin
			pos_q <= job_pos;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (go && emit) begin
			cmd_q  <= {strike ? SLOT_STRIKE : SLOT_RELEASE, code};
			last_q <= last;
		end
	end

	assign empty                 = !out_valid_q;
	assign key_command           = cmd_q;
	assign last_of_run           = last_q;
	assign status.busy           = busy_q;
	assign status.strike_pending = phase_q;
	assign voice                 = voice_q;

endmodule

// File: hdl/pattern_step_sequencer_unit.sv
// top level of the pattern step sequencer: configuration registers and part wiring
//
// channel   | handshake              | payload
// ----------+------------------------+------------------------------
// tick in   | push / full            | advance
// command   | empty / pop            | key_command, last_of_run
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A tick is taken whenever the two-entry step queue has room.
// A stepping tick has the back part load the step, then walk every voice in turn,
// with an extra strike phase for each pattern voice that strikes; the walk gives
// at most one command a cycle while the result register has room.
// Reset clears accumulator, position, key state and restores register defaults.
// A full result register stalls the walk; a full step queue raises full.
module pattern_step_sequencer_unit import psseq_pkg::*; #(
	parameter int unsigned VOICE_COUNT = VOICE_COUNT_DEF,
	parameter int unsigned STEP_COUNT  = STEP_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 advance,
	output logic                 empty,
	input  logic                 pop,
	output logic [CMD_W-1:0]     key_command,
	output logic                 last_of_run,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PATTERN_W-1:0] cfg_data
);

	localparam int unsigned VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	logic [PERIOD_W-1:0]  step_period_q;
	logic [INCR_W-1:0]    tick_increment_q;
	logic [MODES_W-1:0]   modes_q;
	logic [PATTERN_W-1:0] patterns_lo_q;
	logic [PATTERN_W-1:0] patterns_hi_q;
	voice_cfg_t           vcfg;

	logic                 take;
	logic                 enq;
	logic [POS_W-1:0]     enq_pos;
	logic                 job_avail;
	logic                 job_take;
	logic [POS_W-1:0]     job_pos;
	logic [QCNT_W-1:0]    q_count;
	back_status_t         bstat;
	logic [VOICE_W-1:0]   voice;
	logic                 pop_ok;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;
	assign pop_ok    = pop && !empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q    <= RST_STEP_PERIOD;
			tick_increment_q <= RST_TICK_INCREMENT;
			modes_q          <= RST_CHANNEL_MODES;
			patterns_lo_q    <= '0;
			patterns_hi_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_PERIOD:    step_period_q    <= cfg_data[PERIOD_W-1:0];
				REG_TICK_INCREMENT: tick_increment_q <= cfg_data[INCR_W-1:0];
				REG_CHANNEL_MODES:  modes_q          <= cfg_data[MODES_W-1:0];
				REG_PATTERNS_LO:    patterns_lo_q    <= cfg_data;
				REG_PATTERNS_HI:    patterns_hi_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vcfg.modes       = modes_q;
	assign vcfg.patterns_lo = patterns_lo_q;
	assign vcfg.patterns_hi = patterns_hi_q;

	psseq_front #(
		.STEP_COUNT(STEP_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.advance        (advance),
		.step_period    (step_period_q),
		.tick_increment (tick_increment_q),
		.enq            (enq),
		.enq_pos        (enq_pos)
	);

	psseq_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (enq),
		.wr_data (enq_pos),
		.rd      (job_take),
		.rd_data (job_pos),
		.full    (full),
		.avail   (job_avail),
		.count   (q_count)
	);

	psseq_back #(
		.VOICE_COUNT(VOICE_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (vcfg),
		.job_avail   (job_avail),
		.job_pos     (job_pos),
		.job_take    (job_take),
		.pop         (pop_ok),
		.empty       (empty),
		.key_command (key_command),
		.last_of_run (last_of_run),
		.status      (bstat),
		.voice       (voice)
	);

`ifndef SYNTHESIS
	// queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("step queue overfilled");

	// walk index stays within the voices while busy
	a_voice_range: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.busy |-> (voice <= VOICE_W'(VOICE_COUNT - 1)))
		else $error("voice index out of range");

	// an idle back part has no walk state left over
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!bstat.busy |-> (voice == '0 && !bstat.strike_pending))
		else $error("idle back part holds walk state");

	// a queued step is picked up at once by an idle back part
	a_pickup: assert property (@(posedge clk) disable iff (!arst_n)
		(!bstat.busy && job_avail) |=> bstat.busy)
		else $error("queued step not started");
`endif

endmodule

// File: tb/key_command_checker.sv
// checker of the step sequencer: predicts the key commands of each tick and compares them
module key_command_checker import psseq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic                 advance,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [CMD_W-1:0]     key_command,
	input  logic                 last_of_run,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PATTERN_W-1:0] cfg_data,
	output int                   mismatches,
	output int                   commands_waiting,
	output int                   commands_checked,
	output int                   steps_taken
);

	localparam int unsigned VOICES = VOICE_COUNT_DEF;

	// key register channel codes, voice 0 in the low nibble
	localparam logic [VOICES*CODE_W-1:0] KEY_CODES = {4'd6, 4'd5, 4'd4, 4'd2, 4'd1, 4'd0};

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             last;
	} key_event_t;

	key_event_t expected_commands[$];

	// predicted registers and sequencer state
	logic [PERIOD_W-1:0]  period_cfg;
	logic [INCR_W-1:0]    incr_cfg;
	logic [MODES_W-1:0]   modes_cfg;
	logic [PATTERN_W-1:0] pat_lo_cfg;
	logic [PATTERN_W-1:0] pat_hi_cfg;
	logic [ACC_W-1:0]     acc_model;
	logic [POS_W-1:0]     position;
	logic [VOICES-1:0]    held;

	// the newest command of a step is kept back until the walk shows whether it is the last
	logic [CMD_W-1:0] staged_command;
	bit               staged;

	int step_total;
	int checked_total;
	int error_total;

	task automatic stage_command(input logic [CODE_W-1:0] slot, input logic [CODE_W-1:0] code);
		key_event_t ev;
		if (staged) begin
			ev.command = staged_command;
			ev.last    = 1'b0;
			expected_commands.push_back(ev);
		end
		staged_command = {slot, code};
		staged         = 1'b1;
	endtask

	// one tick: accumulate with saturation, step at most once, walk the voices
	task automatic advance_sequencer();
		logic [ACC_W:0]      sum;
		logic [1:0]          mode;
		logic [LANE_W-1:0]   lane;
		logic [CODE_W-1:0]   code;
		key_event_t          ev;
		sum = {1'b0, acc_model} + {{(ACC_W + 1 - INCR_W){1'b0}}, incr_cfg};
		acc_model = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
		if (acc_model < {{(ACC_W - PERIOD_W){1'b0}}, period_cfg})
			return;
		acc_model = acc_model - {{(ACC_W - PERIOD_W){1'b0}}, period_cfg};
		position  = position + 1'b1;
		step_total++;
		staged = 1'b0;
		for (int v = 0; v < VOICES; v++) begin
			mode = modes_cfg[2*v +: 2];
			code = KEY_CODES[CODE_W*v +: CODE_W];
			lane = (v < 3) ? pat_lo_cfg[LANE_W*(v % 3) +: LANE_W]
			               : pat_hi_cfg[LANE_W*(v % 3) +: LANE_W];
			case (mode)
				MODE_SILENT: begin
					if (held[v]) begin
						stage_command(SLOT_RELEASE, code);
						held[v] = 1'b0;
					end
				end
				MODE_PATTERN: begin
					stage_command(SLOT_RELEASE, code);
					held[v] = 1'b0;
					if (lane[position]) begin
						stage_command(SLOT_STRIKE, code);
						held[v] = 1'b1;
					end
				end
				default: begin
					// hold, the spare mode code acts the same
					if (!held[v]) begin
						stage_command(SLOT_STRIKE, code);
						held[v] = 1'b1;
					end
				end
			endcase
		end
		if (staged) begin
			ev.command = staged_command;
			ev.last    = 1'b1;
			expected_commands.push_back(ev);
		end
	endtask

	// follow the three channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		key_event_t want;
		int         errs;
		if (!arst_n) begin
			period_cfg    = RST_STEP_PERIOD;
			incr_cfg      = RST_TICK_INCREMENT;
			modes_cfg     = RST_CHANNEL_MODES;
			pat_lo_cfg    = '0;
			pat_hi_cfg    = '0;
			acc_model     = '0;
			position      = '0;
			held          = '0;
			staged        = 1'b0;
			step_total    = 0;
			checked_total = 0;
			error_total   = 0;
			expected_commands.delete();
			mismatches       <= 0;
			commands_waiting <= 0;
			commands_checked <= 0;
			steps_taken      <= 0;
		end else begin
			errs = 0;
			// register write request
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEP_PERIOD:    period_cfg = cfg_data[PERIOD_W-1:0];
					REG_TICK_INCREMENT: incr_cfg   = cfg_data[INCR_W-1:0];
					REG_CHANNEL_MODES:  modes_cfg  = cfg_data[MODES_W-1:0];
					REG_PATTERNS_LO:    pat_lo_cfg = cfg_data;
					REG_PATTERNS_HI:    pat_hi_cfg = cfg_data;
					default: ;
				endcase
			end
			// tick request
			if (push && !full && advance)
				advance_sequencer();
			// command request
			if (pop && !empty) begin
				if (expected_commands.size() == 0) begin
					$display("%0t: key_command %02h / last %0b arrived with nothing expected",
						$time, key_command, last_of_run);
					errs++;
				end else begin
					want = expected_commands.pop_front();
					checked_total++;
					if (key_command !== want.command) begin
						$display("%0t: key_command expected %02h actual %02h",
							$time, want.command, key_command);
						errs++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %0b actual %0b",
							$time, want.last, last_of_run);
						errs++;
					end
				end
			end
			error_total += errs;
			mismatches       <= error_total;
			commands_waiting <= expected_commands.size();
			commands_checked <= checked_total;
			steps_taken      <= step_total;
		end
	end

endmodule

// File: tb/testbench.sv
// top of the step sequencer testbench: clock, reset, tick and register stimulus, verdict
module testbench;
	import psseq_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 2000;

	// first index that names no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 push        = 1'b0;
	logic                 full;
	logic                 advance     = 1'b0;
	logic                 empty;
	logic                 pop         = 1'b0;
	logic [CMD_W-1:0]     key_command;
	logic                 last_of_run;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [PATTERN_W-1:0] cfg_data    = '0;

	int mismatches;
	int commands_waiting;
	int commands_checked;
	int steps_taken;

	int          ticks_sent   = 0;
	int          stall_cycles = 0;
	int          pop_phase    = 0;
	logic [15:0] pop_mask     = 16'hFFFF;

	pattern_step_sequencer_unit i_dut (.*);

	key_command_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver stalls on a random pop mask
	always @(posedge clk) begin
		pop_phase <= pop_phase + 1;
		if (pop_phase % 64 == 0) begin
			case ($urandom_range(0, 7))
				0, 1:    pop_mask <= 16'hFFFF;
				2:       pop_mask <= 16'($urandom & $urandom & $urandom) | 16'h0001;
				default: pop_mask <= 16'($urandom) | 16'h0001;
			endcase
		end
		pop <= pop_mask[pop_phase % 16];
	end

	// watchdog on cycles without any request
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		do @(posedge clk); while (commands_waiting != 0);
	endtask

	// quiet ticks give no command, so the block may still be walking when the queue is empty
	task automatic settle();
		push <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_tick(input logic tick_bit);
		push    <= 1'b1;
		advance <= tick_bit;
		do @(posedge clk); while (full);
		if (tick_bit)
			ticks_sent++;
	endtask

	// ticks in bursts, with random gaps and now and then a full drain
	task automatic send_ticks(input int count, input int pct_one, input bit gaps);
		int left_in_burst;
		int gap;
		left_in_burst = $urandom_range(1, 8);
		for (int i = 0; i < count; i++) begin
			send_tick($urandom_range(0, 99) < pct_one);
			left_in_burst--;
			if (left_in_burst == 0 && gaps) begin
				left_in_burst = $urandom_range(1, 8);
				if ($urandom_range(0, 15) == 0) begin
					push <= 1'b0;
					wait_drained();
				end else begin
					gap = $urandom_range(0, 6);
					if (gap > 0) begin
						push <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [PATTERN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// random bits above a register's width, which the block must ignore
	function automatic logic [PATTERN_W-1:0] pad_random(input logic [PATTERN_W-1:0] value,
		input int unsigned width);
		logic [PATTERN_W-1:0] noise;
		noise = PATTERN_W'({$urandom, $urandom});
		return (noise << width) | value;
	endfunction

	task automatic load_settings(input logic [PERIOD_W-1:0] period, input logic [INCR_W-1:0] incr,
		input logic [MODES_W-1:0] modes, input logic [PATTERN_W-1:0] pat_lo,
		input logic [PATTERN_W-1:0] pat_hi);
		settle();
		write_reg(REG_STEP_PERIOD, pad_random(PATTERN_W'(period), PERIOD_W));
		write_reg(REG_TICK_INCREMENT, pad_random(PATTERN_W'(incr), INCR_W));
		write_reg(REG_CHANNEL_MODES, pad_random(PATTERN_W'(modes), MODES_W));
		write_reg(REG_PATTERNS_LO, pat_lo);
		write_reg(REG_PATTERNS_HI, pat_hi);
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, 2**CFG_IDX_W - 1)),
				PATTERN_W'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int                   random_start;
		int                   checked_start;
		int                   rounds;
		logic [PERIOD_W-1:0]  period;
		logic [INCR_W-1:0]    incr;
		logic [MODES_W-1:0]   modes;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one step after sixteen ticks, an idle tick in between
		send_ticks(8, 100, 1'b0);
		send_ticks(1, 0, 1'b0);
		send_ticks(8, 100, 1'b0);

		// zero period, every mode including the spare hold code, full pattern lane
		load_settings(10'd0, 8'd0, 12'h1C9, '1, 48'hAAAA_5555_F0F0);
		send_ticks(3, 100, 1'b0);

		// longest period, largest increment, all silent: held keys let go
		load_settings(10'd1023, 8'd255, 12'h000, '0, '0);
		send_ticks(5, 100, 1'b0);

		// random settings, biased so that steps come often
		random_start  = ticks_sent;
		checked_start = commands_checked;
		rounds        = 0;
		while ((ticks_sent - random_start < 60 || commands_checked - checked_start < 40)
			&& rounds < 10) begin
			rounds++;
			case ($urandom_range(0, 7))
				0:       incr = 8'd0;
				1:       incr = 8'd255;
				default: incr = INCR_W'($urandom_range(1, 254));
			endcase
			case ($urandom_range(0, 7))
				0:       period = 10'd0;
				1:       period = 10'd1;
				2:       period = 10'd1023;
				default: period = PERIOD_W'($urandom_range(0, (3 * incr + 1 > 1023) ? 1023
				                                               : 3 * incr + 1));
			endcase
			modes = ($urandom_range(0, 3) == 0) ? 12'h555 : MODES_W'($urandom);
			load_settings(period, incr, modes, PATTERN_W'({$urandom, $urandom}),
				PATTERN_W'({$urandom, $urandom}));
			send_ticks($urandom_range(8, 20), ($urandom_range(0, 3) == 0) ? 100 : 80,
				$urandom_range(0, 3) != 0);
		end

		settle();
		$display("run covered %0d ticks with advance set and %0d sequencer steps",
			ticks_sent, steps_taken);
		$display("%0d key commands compared, zero period and unknown register writes included",
			commands_checked);
		if (mismatches == 0 && commands_waiting == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
